// File: design/cpac_pkg.sv
// Shared types, constants and the CRC-8 function for the controller pak access block.
package cpac_pkg;

    localparam int BLOCK_BYTES = 32;
    localparam int OFS_W       = $clog2(BLOCK_BYTES);
    localparam int MEM_AW_MAX  = 15;    // widest pak store index carried in a command
    localparam int SCR_AW_MAX  = 8;     // widest scratch index carried in a command

    localparam logic [15:0] ADDR_BLK_MASK  = 16'hFFE0;
    localparam logic [15:0] SCRATCH_BASE   = 16'h8000;
    localparam logic [15:0] RUMBLE_WIN_END = 16'h9000;
    localparam logic [15:0] MOTOR_BLK      = 16'hC000;
    localparam logic [7:0]  RUMBLE_SET     = 8'h80;
    localparam logic [7:0]  CRC_POLY       = 8'h85;
    localparam logic [7:0]  ERASED_BYTE    = 8'hFF;

    localparam logic [1:0] PAK_ABSENT = 2'd0;
    localparam logic [1:0] PAK_MEM    = 2'd1;
    localparam logic [1:0] PAK_MOTOR  = 2'd2;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_MEM,
        KIND_SCR,
        KIND_RUMBLE
    } kind_t;

    // one classified byte, front to back
    typedef struct packed {
        logic                  op;
        kind_t                 kind;
        logic                  first;
        logic                  last;
        logic                  in_window;
        logic                  motor_blk;
        logic [MEM_AW_MAX-1:0] mem_idx;
        logic [SCR_AW_MAX-1:0] scr_idx;
        logic [7:0]            wbyte;
    } cmd_t;

    // CRC-8, MSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] d);
        logic [7:0] r;
        r = crc ^ d;
        for (int i = 0; i < 8; i++) begin
            r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

endpackage

// File: design/cpac_front.sv
// Front end: takes bytes, tracks block offset and address, classifies each byte.
module cpac_front import cpac_pkg::*; #(
    parameter int MEM_DEPTH     = 32768,
    parameter int SCRATCH_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        s_tuser,
    input  logic        clr_busy,
    input  logic        q_full,
    output logic        q_push,
    output cmd_t        q_cmd
);

    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int SCR_AW    = $clog2(SCRATCH_DEPTH);
    localparam int MEM_STEPS = 5;   // depth >= 1024, so a 15-bit address has quotient < 32
    localparam int SCR_STEPS = 3;   // depth >= 32, so a byte has quotient < 8

    logic [1:0]       pak_type_reg;
    logic [OFS_W-1:0] offset_reg;
    logic [15:0]      blk_addr_reg;
    logic [MEM_AW-1:0] mem_nxt_reg, mem_cur, mem_base, mem_nxt_next;
    logic [SCR_AW-1:0] scr_nxt_reg, scr_cur, scr_base, scr_nxt_next;
    logic [15:0]      in_addr, blk_addr;
    logic [19:0]      mem_rem;
    logic [11:0]      scr_rem;
    logic             first, accept;
    kind_t            kind;

    assign s_tready = !q_full && !clr_busy;
    assign accept   = s_tvalid && s_tready;
    assign first    = (offset_reg == '0);
    assign in_addr  = s_tdata[15:0] & ADDR_BLK_MASK;
    assign blk_addr = first ? in_addr : blk_addr_reg;

    // block base modulo the store depths, by restoring subtraction
    always_comb begin
        mem_rem = 20'(in_addr[14:0]);
        for (int i = MEM_STEPS - 1; i >= 0; i--) begin
            if (mem_rem >= (20'(MEM_DEPTH) << i)) begin
                mem_rem = mem_rem - (20'(MEM_DEPTH) << i);
            end
        end
        scr_rem = 12'(in_addr[7:0]);
        for (int i = SCR_STEPS - 1; i >= 0; i--) begin
            if (scr_rem >= (12'(SCRATCH_DEPTH) << i)) begin
                scr_rem = scr_rem - (12'(SCRATCH_DEPTH) << i);
            end
        end
    end

    assign mem_base = mem_rem[MEM_AW-1:0];
    assign scr_base = scr_rem[SCR_AW-1:0];
    assign mem_cur  = first ? mem_base : mem_nxt_reg;
    assign scr_cur  = first ? scr_base : scr_nxt_reg;
    assign mem_nxt_next = (mem_cur == MEM_AW'(MEM_DEPTH - 1)) ? '0 : mem_cur + 1'b1;
    assign scr_nxt_next = (scr_cur == SCR_AW'(SCRATCH_DEPTH - 1)) ? '0 : scr_cur + 1'b1;

    always_comb begin
        case (pak_type_reg)
            PAK_MEM:   kind = (blk_addr < SCRATCH_BASE) ? KIND_MEM : KIND_SCR;
            PAK_MOTOR: kind = KIND_RUMBLE;
            default:   kind = KIND_NONE;
        endcase
    end

    always_comb begin
        q_cmd.op        = s_tuser;
        q_cmd.kind      = kind;
        q_cmd.first     = first;
        q_cmd.last      = (offset_reg == OFS_W'(BLOCK_BYTES - 1));
        q_cmd.in_window = (blk_addr >= SCRATCH_BASE) && (blk_addr < RUMBLE_WIN_END);
        q_cmd.motor_blk = (blk_addr == MOTOR_BLK);
        q_cmd.mem_idx   = MEM_AW_MAX'(mem_cur);
        q_cmd.scr_idx   = SCR_AW_MAX'(scr_cur);
        q_cmd.wbyte     = s_tdata[23:16];
    end

    assign q_push = accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pak_type_reg <= PAK_ABSENT;
            offset_reg   <= '0;
            blk_addr_reg <= '0;
        end else begin
            if (cfg_we) begin
                pak_type_reg <= cfg_wdata;
            end
            if (accept) begin
                offset_reg   <= offset_reg + 1'b1;
                blk_addr_reg <= blk_addr;
                mem_nxt_reg  <= mem_nxt_next;
                scr_nxt_reg  <= scr_nxt_next;
            end
        end
    end

endmodule

// File: design/cpac_queue.sv
// Two-entry command queue between front and back.
module cpac_queue import cpac_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic valid,
    output cmd_t pop_cmd
);

    cmd_t       ent_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full    = (cnt_reg == 2'd2);
    assign valid   = (cnt_reg != 2'd0);
    assign pop_cmd = ent_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

// File: design/cpac_back.sv
// Back end: stores, rumble state, CRC and the result word register.
module cpac_back import cpac_pkg::*; #(
    parameter int MEM_DEPTH     = 32768,
    parameter int SCRATCH_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  cmd_t        q_cmd,
    output logic        q_pop,
    output logic        clr_busy,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic        m_tuser,
    output logic        m_tlast
);

    localparam int MEM_AW = $clog2(MEM_DEPTH);
    localparam int SCR_AW = $clog2(SCRATCH_DEPTH);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DATA,
        ST_CRC
    } state_t;

    logic [7:0] pak_mem [MEM_DEPTH];
    logic [7:0] scr_mem [SCRATCH_DEPTH];

    state_t      state_reg;
    logic [MEM_AW-1:0] clr_cnt_reg;
    logic [7:0]  crc_reg, out_data_reg, pak_rd_reg, scr_rd_reg;
    logic        motor_reg, last_data_reg;
    logic        out_status_reg, out_crc_reg, out_last_reg;
    logic        blk_last_reg, cur_first_reg;
    kind_t       cur_kind_reg;

    logic        clearing, is_store;
    logic        pak_we, scr_we;
    logic [MEM_AW-1:0] pak_waddr;
    logic [SCR_AW-1:0] scr_waddr;
    logic [7:0]  pak_wdata, scr_wdata;
    logic [7:0]  direct_data, data_sel, crc_next;
    logic        first_sel, motor_next, last_data_next;

    assign clearing = (state_reg == ST_CLEAR);
    assign clr_busy = clearing;
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign is_store = (q_cmd.kind == KIND_MEM) || (q_cmd.kind == KIND_SCR);

    // store ports: clear sweep after reset, then command writes
    assign pak_we    = clearing || (q_pop && q_cmd.kind == KIND_MEM && q_cmd.op == OP_WRITE);
    assign pak_waddr = clearing ? clr_cnt_reg : q_cmd.mem_idx[MEM_AW-1:0];
    assign pak_wdata = clearing ? ERASED_BYTE : q_cmd.wbyte;
    assign scr_we    = clearing ? (clr_cnt_reg < MEM_AW'(SCRATCH_DEPTH))
                                : (q_pop && q_cmd.kind == KIND_SCR && q_cmd.op == OP_WRITE);
    assign scr_waddr = clearing ? clr_cnt_reg[SCR_AW-1:0] : q_cmd.scr_idx[SCR_AW-1:0];
    assign scr_wdata = clearing ? 8'h00 : q_cmd.wbyte;

    always_ff @(posedge aclk) begin
        if (pak_we) begin
            pak_mem[pak_waddr] <= pak_wdata;
        end
        pak_rd_reg <= pak_mem[q_cmd.mem_idx[MEM_AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (scr_we) begin
            scr_mem[scr_waddr] <= scr_wdata;
        end
        scr_rd_reg <= scr_mem[q_cmd.scr_idx[SCR_AW-1:0]];
    end

    // byte result for everything but a store read
    always_comb begin
        direct_data    = 8'h00;
        motor_next     = motor_reg;
        last_data_next = last_data_reg;
        case (q_cmd.kind)
            KIND_MEM, KIND_SCR: direct_data = q_cmd.wbyte;
            KIND_RUMBLE: begin
                if (q_cmd.op == OP_WRITE) begin
                    direct_data = q_cmd.wbyte;
                    if (q_cmd.first && q_cmd.motor_blk) begin
                        motor_next = (q_cmd.wbyte != 8'h00);
                    end else if (q_cmd.first && q_cmd.in_window) begin
                        last_data_next = (q_cmd.wbyte != 8'h00);
                    end
                end else if (q_cmd.in_window) begin
                    direct_data = last_data_reg ? RUMBLE_SET : 8'h00;
                    motor_next  = 1'b0;
                end
            end
            default: direct_data = 8'h00;
        endcase
    end

    assign data_sel  = (state_reg == ST_READ)
                     ? ((cur_kind_reg == KIND_MEM) ? pak_rd_reg : scr_rd_reg)
                     : direct_data;
    assign first_sel = (state_reg == ST_READ) ? cur_first_reg : q_cmd.first;
    assign crc_next  = crc8_byte(first_sel ? 8'h00 : crc_reg, data_sel);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            crc_reg       <= 8'h00;
            motor_reg     <= 1'b0;
            last_data_reg <= 1'b1;
        end else begin
            case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == MEM_AW'(MEM_DEPTH - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (q_valid) begin
                        blk_last_reg   <= q_cmd.last;
                        cur_first_reg  <= q_cmd.first;
                        cur_kind_reg   <= q_cmd.kind;
                        out_status_reg <= (q_cmd.kind == KIND_NONE);
                        out_crc_reg    <= 1'b0;
                        out_last_reg   <= !q_cmd.last;
                        if (is_store && q_cmd.op == OP_READ) begin
                            state_reg <= ST_READ;
                        end else begin
                            out_data_reg  <= direct_data;
                            crc_reg       <= crc_next;
                            motor_reg     <= motor_next;
                            last_data_reg <= last_data_next;
                            state_reg     <= ST_DATA;
                        end
                    end
                end
                ST_READ: begin
                    out_data_reg <= data_sel;
                    crc_reg      <= crc_next;
                    state_reg    <= ST_DATA;
                end
                ST_DATA: begin
                    if (m_tready) begin
                        if (blk_last_reg) begin
                            out_data_reg <= crc_reg;
                            out_crc_reg  <= 1'b1;
                            out_last_reg <= 1'b1;
                            state_reg    <= ST_CRC;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_CRC: begin
                    if (m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = (state_reg == ST_DATA) || (state_reg == ST_CRC);
    assign m_tdata  = {6'b0, motor_reg, out_status_reg, out_data_reg};
    assign m_tuser  = out_crc_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: design/controller_pak_access_crc_top.sv
// Top level of the controller pak block access engine with CRC-8 trailer.
// Path: an accepted byte passes through the queue entry and the back-end result register,
// and a read from the pak store or scratch area also through the registered store read; the
// CRC word follows the 32nd byte word once that word is taken. The back-end sequencer runs
// one word at a time and takes no new byte until its word is taken; a 2-word queue decouples.
// Reset: synchronous, active low; afterwards a clearing pass over every pak store address
// erases the pak store to 0xFF and zeroes the scratch area, with s_tready low throughout.
module controller_pak_access_crc_top import cpac_pkg::*; #(
    parameter int MEM_DEPTH     = 32768,   // pak store bytes, 1024..32768
    parameter int SCRATCH_DEPTH = 256      // scratch area bytes, 32..256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // pak type register: 0 none, 1 memory pak, 2 rumble pak
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    // byte words in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [15:0] address, [23:16] write_byte
    input  logic        s_tuser,    // [0] op: 0 read, 1 write
    // result words out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] data_byte, [8] status, [9] motor_on, rest zero
    output logic        m_tuser,    // [0] is_crc
    output logic        m_tlast     // last word of the input byte
);

    cmd_t front_cmd, back_cmd;
    logic q_push, q_full, q_pop, q_valid, clr_busy;

    // Front: offset counter, block address latch, index and class per byte.
    cpac_front #(
        .MEM_DEPTH     (MEM_DEPTH),
        .SCRATCH_DEPTH (SCRATCH_DEPTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .clr_busy  (clr_busy),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (front_cmd)
    );

    // Short queue so the front keeps taking bytes while a result waits.
    cpac_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (front_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_cmd  (back_cmd)
    );

    // Back: stores, rumble flag and motor, CRC, result register.
    cpac_back #(
        .MEM_DEPTH     (MEM_DEPTH),
        .SCRATCH_DEPTH (SCRATCH_DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (back_cmd),
        .q_pop    (q_pop),
        .clr_busy (clr_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
